// ----- sv/twma_pkg.sv -----
// Package for the time window metric aggregator: shared widths, constants and codes.
// No dependencies.
`timescale 1ns / 1ps
package twma_pkg;
  localparam int TimeW = 48;
  localparam int ValW = 64;
  localparam int DepthDefault = 64;
  localparam logic [31:0] HoldReset = 32'd300000;
  localparam logic [9:0] RateScale = 10'd1000;

  typedef enum logic [2:0] {
    MODE_LATEST = 3'd0,
    MODE_MAX    = 3'd1,
    MODE_MIN    = 3'd2,
    MODE_SUM    = 3'd3,
    MODE_QPS    = 3'd4,
    MODE_TPUT   = 3'd5
  } mode_t;

  localparam logic [0:0] FuncAppend = 1'b0;
  localparam logic [0:0] FuncCollect = 1'b1;

  // Divider control between sequencer and divider.
  typedef struct packed {
    logic start;
    logic neg_num;
    logic neg_den;
  } div_ctl_t;
endpackage

// ----- sv/time_window_metric_aggregator.sv -----
// Top level of the time window metric aggregator: APB registers, sample queue and sequencer.
// Depends on twma_pkg and twma_div.
`timescale 1ns / 1ps
// An append stores the sample and then drops samples from the head by age, one
// by one through the queue memory's single registered read port; the first
// append after reset only stores the sample and records its timestamp. A collect
// reads every queued sample through the same port, one a cycle, and returns an
// empty result on an empty queue; the rate modes also run the bit-serial divider
// unless the interval is zero. busy is high throughout; the single result beat is
// shown on out_valid for one cycle and must be taken then.
module time_window_metric_aggregator #(
  parameter int QUEUE_DEPTH = twma_pkg::DepthDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_func,
  input  logic [twma_pkg::TimeW-1:0] in_sample_time,
  input  logic signed [twma_pkg::ValW-1:0] in_sample_value,
  output logic                      out_valid,
  output logic                      out_empty_res,
  output logic [twma_pkg::TimeW-1:0] out_report_time,
  output logic signed [twma_pkg::ValW-1:0] out_report_value,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = twma_pkg::TimeW;
  localparam int VW = twma_pkg::ValW;
  localparam logic [2:0] AddrMode = 3'd0;
  localparam logic [2:0] AddrHold = 3'd4;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_PUSH  = 8'b00000010,
    ST_RDH   = 8'b00000100,
    ST_CHK   = 8'b00001000,
    ST_SCAN  = 8'b00010000,
    ST_FIN   = 8'b00100000,
    ST_DIV   = 8'b01000000,
    ST_OUT   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]  mode_r;
  logic [31:0] hold_r;

  logic [TW-1:0] mem_t [QUEUE_DEPTH];
  logic [VW-1:0] mem_v [QUEUE_DEPTH];
  logic [TW-1:0] rd_t_r;
  logic [VW-1:0] rd_v_r;
  logic [IdxW-1:0] rd_addr;
  logic          we;
  logic [IdxW-1:0] wr_addr;

  logic [IdxW-1:0] head_r, head_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [TW-1:0]   lct_r, lct_nxt;
  logic            started_r, started_nxt;
  logic [TW-1:0]   newt_r, newt_nxt;
  logic [VW-1:0]   newv_r, newv_nxt;
  logic [CntW-1:0] scan_r, scan_nxt;
  logic            rd_live_r, rd_live_nxt;
  logic [VW-1:0]   sum_r, sum_nxt, mx_r, mx_nxt, mn_r, mn_nxt, last_r, last_nxt;
  logic            first_r, first_nxt;
  logic [VW-1:0]   res_r, res_nxt;
  logic            empty_r, empty_nxt, oval_r, oval_nxt;
  logic [TW-1:0]   rtime_r, rtime_nxt;
  logic [VW-1:0]   scaled_r, scaled_nxt, ivl_r, ivl_nxt;

  twma_pkg::div_ctl_t div_ctl;
  logic          div_done;
  logic [VW-1:0] div_q, num_mag, den_mag;

  // Register access.
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr)
      AddrMode: prdata = {29'd0, mode_r};
      AddrHold: prdata = hold_r;
      default:  prdata = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 3'd0;
      hold_r <= twma_pkg::HoldReset;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrMode) mode_r <= pwdata[2:0];
      if (paddr == AddrHold) hold_r <= pwdata;
    end
  end

  function automatic logic [IdxW-1:0] slot(input logic [IdxW-1:0] h,
                                           input logic [CntW-1:0] off);
    logic [CntW:0] s;
    begin
      s = (CntW+1)'(h) + (CntW+1)'(off);
      if (s >= (CntW+1)'(QUEUE_DEPTH)) s = s - (CntW+1)'(QUEUE_DEPTH);
      return s[IdxW-1:0];
    end
  endfunction

  // Queue memory with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_t[wr_addr] <= newt_r;
      mem_v[wr_addr] <= newv_r;
    end
    rd_t_r <= mem_t[rd_addr];
    rd_v_r <= mem_v[rd_addr];
  end

  // Age of the head sample behind the newest, signed.
  logic signed [TW:0] age;
  logic signed [TW:0] ivl;
  assign age = $signed({1'b0, newt_r}) - $signed({1'b0, rd_t_r});
  assign ivl = $signed({1'b0, newt_r}) - $signed({1'b0, lct_r});
  assign num_mag = scaled_r[VW-1] ? (~scaled_r + 1'b1) : scaled_r;
  assign den_mag = ivl_r[VW-1] ? (~ivl_r + 1'b1) : ivl_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;
    count_nxt = count_r;
    lct_nxt = lct_r;
    started_nxt = started_r;
    newt_nxt = newt_r;
    newv_nxt = newv_r;
    scan_nxt = scan_r;
    rd_live_nxt = 1'b0;
    sum_nxt = sum_r;
    mx_nxt = mx_r;
    mn_nxt = mn_r;
    last_nxt = last_r;
    first_nxt = first_r;
    res_nxt = res_r;
    empty_nxt = empty_r;
    rtime_nxt = rtime_r;
    oval_nxt = 1'b0;
    scaled_nxt = scaled_r;
    ivl_nxt = ivl_r;
    we = 1'b0;
    wr_addr = slot(head_r, count_r);
    rd_addr = head_r;
    div_ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        // No beat is taken while the result beat is still on the outputs.
        if (start && !oval_r) begin
          newt_nxt = in_sample_time;
          newv_nxt = in_sample_value;
          if (in_func == twma_pkg::FuncAppend) begin
            state_nxt = ST_PUSH;
          end else if (count_r == '0) begin
            empty_nxt = 1'b1;
            rtime_nxt = '0;
            res_nxt = '0;
            state_nxt = ST_OUT;
          end else begin
            scan_nxt = '0;
            sum_nxt = '0;
            first_nxt = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_PUSH: begin
        // Full queue drops its oldest sample silently.
        if (count_r == CntW'(QUEUE_DEPTH)) begin
          head_nxt = slot(head_r, CntW'(1));
          wr_addr = head_r;
        end else begin
          count_nxt = count_r + 1'b1;
        end
        we = 1'b1;
        if (!started_r) begin
          lct_nxt = newt_r;
          started_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RDH;
        end
      end
      ST_RDH: begin
        rd_addr = head_r;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (count_r != '0 && age >= $signed({17'd0, hold_r})) begin
          lct_nxt = rd_t_r;
          head_nxt = slot(head_r, CntW'(1));
          count_nxt = count_r - 1'b1;
          state_nxt = ST_RDH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Read one slot a cycle; fold the value read the cycle before.
        rd_addr = slot(head_r, scan_r);
        if (scan_r != count_r) begin
          rd_live_nxt = 1'b1;
          scan_nxt = scan_r + 1'b1;
        end
        if (rd_live_r) begin
          sum_nxt = sum_r + rd_v_r;
          last_nxt = rd_v_r;
          newt_nxt = rd_t_r;
          first_nxt = 1'b0;
          if (first_r || $signed(rd_v_r) > $signed(mx_r)) mx_nxt = rd_v_r;
          if (first_r || $signed(rd_v_r) < $signed(mn_r)) mn_nxt = rd_v_r;
        end
        if (scan_r == count_r && !rd_live_r) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        empty_nxt = 1'b0;
        rtime_nxt = newt_r;
        scaled_nxt = sum_r * VW'(twma_pkg::RateScale);
        ivl_nxt = VW'(ivl);
        lct_nxt = newt_r;
        head_nxt = '0;
        count_nxt = '0;
        state_nxt = ST_OUT;
        unique case (mode_r)
          twma_pkg::MODE_MAX: res_nxt = mx_r;
          twma_pkg::MODE_MIN: res_nxt = mn_r;
          twma_pkg::MODE_SUM: res_nxt = sum_r;
          twma_pkg::MODE_QPS, twma_pkg::MODE_TPUT: begin
            if (ivl == '0) res_nxt = '0;
            else state_nxt = ST_DIV;
          end
          default: res_nxt = last_r;
        endcase
      end
      ST_DIV: begin
        div_ctl.start = (scan_r != '0);
        div_ctl.neg_num = scaled_r[VW-1];
        div_ctl.neg_den = ivl_r[VW-1];
        scan_nxt = '0;
        if (div_done) begin
          res_nxt = div_q;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        oval_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  twma_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(div_ctl),
    .num_mag(num_mag), .den_mag(den_mag), .done(div_done), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r <= '0;
      count_r <= '0;
      lct_r <= '0;
      started_r <= 1'b0;
      oval_r <= 1'b0;
      rd_live_r <= 1'b0;
      scan_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      count_r <= count_nxt;
      lct_r <= lct_nxt;
      started_r <= started_nxt;
      oval_r <= oval_nxt;
      rd_live_r <= rd_live_nxt;
      scan_r <= scan_nxt;
    end
    newt_r <= newt_nxt;
    newv_r <= newv_nxt;
    sum_r <= sum_nxt;
    mx_r <= mx_nxt;
    mn_r <= mn_nxt;
    last_r <= last_nxt;
    first_r <= first_nxt;
    res_r <= res_nxt;
    empty_r <= empty_nxt;
    rtime_r <= rtime_nxt;
    scaled_r <= scaled_nxt;
    ivl_r <= ivl_nxt;
  end

  assign busy = (state_r != ST_IDLE) || oval_r;
  assign out_valid = oval_r;
  assign out_empty_res = empty_r;
  assign out_report_time = rtime_r;
  assign out_report_value = res_r;

  // The fill count never passes the queue depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CntW'(QUEUE_DEPTH))
    else $error("queue count overflow");
  // A result beat always follows the output state.
  assert property (@(posedge clk) disable iff (!rst_n) state_r == ST_OUT |=> out_valid)
    else $error("missing result beat");
  // A collect always leaves the queue empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_empty_res) |-> count_r == '0)
    else $error("queue not emptied by collect");
endmodule

// ----- sv/twma_div.sv -----
// Restoring divider, one quotient bit per cycle, signed by magnitude and sign fix.
// Depends on twma_pkg.
`timescale 1ns / 1ps
module twma_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  twma_pkg::div_ctl_t        ctl,
  input  logic [twma_pkg::ValW-1:0] num_mag,
  input  logic [twma_pkg::ValW-1:0] den_mag,
  output logic                      done,
  output logic [twma_pkg::ValW-1:0] quot
);
  localparam int CntW = $clog2(twma_pkg::ValW + 1);

  logic [twma_pkg::ValW-1:0] q_r, q_nxt, den_r, den_nxt;
  logic [twma_pkg::ValW:0]   rem_r, rem_nxt, trial;
  logic [CntW-1:0]           cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;

  // Shift one numerator bit into the partial remainder and try a subtract.
  always_comb begin
    q_nxt = q_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    trial = {rem_r[twma_pkg::ValW-1:0], q_r[twma_pkg::ValW-1]} - {1'b0, den_r};
    if (ctl.start) begin
      q_nxt = num_mag;
      den_nxt = den_mag;
      rem_nxt = '0;
      cnt_nxt = CntW'(twma_pkg::ValW);
      busy_nxt = 1'b1;
      neg_nxt = ctl.neg_num ^ ctl.neg_den;
    end else if (busy_r) begin
      if (!trial[twma_pkg::ValW]) begin
        rem_nxt = trial;
        q_nxt = {q_r[twma_pkg::ValW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[twma_pkg::ValW-1:0], q_r[twma_pkg::ValW-1]};
        q_nxt = {q_r[twma_pkg::ValW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quot = neg_r ? (~q_r + 1'b1) : q_r;
endmodule
